FILE: src/text_stream_line_numberer_core_macros.svh
// Assertion macros shared by the line numberer RTL files
`ifndef TEXT_STREAM_LINE_NUMBERER_CORE_MACROS_SVH
`define TEXT_STREAM_LINE_NUMBERER_CORE_MACROS_SVH

// Same-cycle implication, checked on every rising clock edge out of reset
`define TSLN_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked on every rising clock edge out of reset
`define TSLN_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: src/tsln_pkg.sv
// Shared constants, command type and helpers for the line numberer
`default_nettype none

package tsln_pkg;

    // Line number width in decimal digits
    localparam int NUMBER_DIGITS = 6;
    localparam int BCD_W         = 4 * NUMBER_DIGITS;

    // Output position within one command: digits, two spaces, one or two body bytes
    localparam int POS_BODY      = NUMBER_DIGITS + 2;
    localparam int POS_W         = $clog2(NUMBER_DIGITS + 4);

    // Command queue between front and back
    localparam int CMD_DEPTH     = 4;
    localparam int CMD_PTR_W     = $clog2(CMD_DEPTH);
    localparam int CMD_CNT_W     = $clog2(CMD_DEPTH + 1);

    // Configuration register indexes
    localparam int CFG_IDX_W     = 3;
    localparam logic [CFG_IDX_W-1:0] CFG_NUMBER_ALL      = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_NUMBER_NONBLANK = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SQUEEZE_BLANK   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SHOW_ENDS       = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_SHOW_TABS       = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_SHOW_NONPRINT   = 3'd5;

    // Character codes
    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_NL     = 8'h0A;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_DOLLAR = 8'h24;
    localparam logic [7:0] CH_ZERO   = 8'h30;
    localparam logic [7:0] CH_QMARK  = 8'h3F;
    localparam logic [7:0] CH_CARET  = 8'h5E;
    localparam logic [7:0] CH_UPPERI = 8'h49;
    localparam logic [7:0] CH_DEL    = 8'h7F;
    localparam logic [7:0] CTRL_OFS  = 8'h40;

    // One classified input byte: optional line number plus one or two body bytes
    typedef struct packed {
        logic              has_num;
        logic [BCD_W-1:0]  digits;
        logic [7:0]        body0;
        logic [7:0]        body1;
        logic              two_body;
    } cmd_t;

    // True when every BCD digit is in 0..9
    function automatic logic bcd_valid(input logic [BCD_W-1:0] v);
        logic ok;
        ok = 1'b1;
        for (int i = 0; i < NUMBER_DIGITS; i++)
        begin
            if (v[4*i +: 4] > 4'd9)
            begin
                ok = 1'b0;
            end
        end
        return ok;
    endfunction

endpackage

`default_nettype wire

FILE: src/tsln_front.sv
// Front end: config registers, line state, byte classification into commands
`default_nettype none

module tsln_front (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           cfg_we,
    input  wire logic [tsln_pkg::CFG_IDX_W-1:0] cfg_index,
    input  wire logic                           cfg_data,
    input  wire logic                           push,
    input  wire logic [7:0]                     in_byte,
    output logic                                full,
    output logic                                cmd_wr,
    output tsln_pkg::cmd_t                      cmd_data,
    input  wire logic                           cmd_full
);
    import tsln_pkg::*;

`include "text_stream_line_numberer_core_macros.svh"

    localparam logic [BCD_W-1:0] BCD_ONE = BCD_W'(1);

    // Saturating BCD increment, ripple over the digits
    function automatic logic [BCD_W-1:0] bcd_inc(input logic [BCD_W-1:0] v);
        logic [BCD_W-1:0] r;
        logic             carry;
        logic             all9;
        r     = v;
        carry = 1'b1;
        all9  = 1'b1;
        for (int i = 0; i < NUMBER_DIGITS; i++)
        begin
            if (v[4*i +: 4] != 4'd9)
            begin
                all9 = 1'b0;
            end
        end
        for (int i = 0; i < NUMBER_DIGITS; i++)
        begin
            if (carry)
            begin
                if (v[4*i +: 4] >= 4'd9)
                begin
                    r[4*i +: 4] = 4'd0;
                end
                else
                begin
                    r[4*i +: 4] = v[4*i +: 4] + 4'd1;
                    carry       = 1'b0;
                end
            end
        end
        return all9 ? v : r;
    endfunction

    logic             number_all_reg;
    logic             number_nonblank_reg;
    logic             squeeze_blank_reg;
    logic             show_ends_reg;
    logic             show_tabs_reg;
    logic             show_nonprint_reg;

    logic [1:0]       blank_run_reg;
    logic [1:0]       blank_run_next;
    logic [BCD_W-1:0] line_count_reg;
    logic [BCD_W-1:0] line_count_next;
    logic             at_line_start_reg;
    logic             at_line_start_next;

    logic             accept;
    logic             is_nl;
    logic             drop;
    logic             do_num;
    cmd_t             cmd;

    // Configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            number_all_reg      <= 1'b0;
            number_nonblank_reg <= 1'b0;
            squeeze_blank_reg   <= 1'b0;
            show_ends_reg       <= 1'b0;
            show_tabs_reg       <= 1'b0;
            show_nonprint_reg   <= 1'b0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_NUMBER_ALL:      number_all_reg      <= cfg_data;
                CFG_NUMBER_NONBLANK: number_nonblank_reg <= cfg_data;
                CFG_SQUEEZE_BLANK:   squeeze_blank_reg   <= cfg_data;
                CFG_SHOW_ENDS:       show_ends_reg       <= cfg_data;
                CFG_SHOW_TABS:       show_tabs_reg       <= cfg_data;
                CFG_SHOW_NONPRINT:   show_nonprint_reg   <= cfg_data;
                default:             ;
            endcase
        end
    end

    // Classify the incoming byte
    assign full   = cmd_full;
    assign accept = push && !cmd_full;
    assign is_nl  = (in_byte == CH_NL);
    assign drop   = is_nl && squeeze_blank_reg && (blank_run_reg >= 2'd2);
    assign do_num = at_line_start_reg &&
                    ((number_all_reg && !number_nonblank_reg) ||
                     (number_nonblank_reg && !is_nl));

    always_comb
    begin
        cmd.has_num  = do_num;
        cmd.digits   = line_count_reg;
        cmd.body0    = in_byte;
        cmd.body1    = in_byte;
        cmd.two_body = 1'b0;
        priority if (is_nl)
        begin
            cmd.body0    = show_ends_reg ? CH_DOLLAR : CH_NL;
            cmd.body1    = CH_NL;
            cmd.two_body = show_ends_reg;
        end
        else if (in_byte == CH_TAB && show_tabs_reg)
        begin
            cmd.body0    = CH_CARET;
            cmd.body1    = CH_UPPERI;
            cmd.two_body = 1'b1;
        end
        else if (in_byte < CH_SPACE && in_byte != CH_TAB && show_nonprint_reg)
        begin
            cmd.body0    = CH_CARET;
            cmd.body1    = in_byte + CTRL_OFS;
            cmd.two_body = 1'b1;
        end
        else if (in_byte == CH_DEL && show_nonprint_reg)
        begin
            cmd.body0    = CH_CARET;
            cmd.body1    = CH_QMARK;
            cmd.two_body = 1'b1;
        end
        else
        begin
            cmd.two_body = 1'b0;
        end
    end

    assign cmd_wr   = accept && !drop;
    assign cmd_data = cmd;

    // Line state updates
    always_comb
    begin
        blank_run_next     = blank_run_reg;
        line_count_next    = line_count_reg;
        at_line_start_next = at_line_start_reg;
        if (accept && !drop)
        begin
            blank_run_next     = (is_nl && squeeze_blank_reg) ? blank_run_reg + 2'd1 : 2'd0;
            line_count_next    = do_num ? bcd_inc(line_count_reg) : line_count_reg;
            at_line_start_next = is_nl;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            blank_run_reg     <= 2'd0;
            line_count_reg    <= BCD_ONE;
            at_line_start_reg <= 1'b1;
        end
        else
        begin
            blank_run_reg     <= blank_run_next;
            line_count_reg    <= line_count_next;
            at_line_start_reg <= at_line_start_next;
        end
    end

    // Checks
    `TSLN_ASSERT_NEXT(a_drop_keeps_count, accept && drop, $stable(line_count_reg) && $stable(at_line_start_reg), "dropped newline changed line state")
    `TSLN_ASSERT_NOW(a_bcd_digits_valid, 1'b1, bcd_valid(line_count_reg), "line counter holds a non-decimal digit")
    `TSLN_ASSERT_NOW(a_blank_run_bound, 1'b1, blank_run_reg <= 2'd2, "blank run counter out of range")

endmodule

`default_nettype wire

FILE: src/tsln_cmd_queue.sv
// Short command queue between the front end and the output sequencer
`default_nettype none

module tsln_cmd_queue (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           wr,
    input  tsln_pkg::cmd_t      wr_data,
    output logic                full,
    input  wire logic           rd,
    output tsln_pkg::cmd_t      rd_data,
    output logic                empty
);
    import tsln_pkg::*;

    cmd_t                 slot_reg [CMD_DEPTH];
    logic [CMD_PTR_W-1:0] wr_ptr_reg;
    logic [CMD_PTR_W-1:0] rd_ptr_reg;
    logic [CMD_CNT_W-1:0] count_reg;
    logic                 do_wr;
    logic                 do_rd;

    assign full    = (count_reg == CMD_CNT_W'(CMD_DEPTH));
    assign empty   = (count_reg == '0);
    assign do_wr   = wr && !full;
    assign do_rd   = rd && !empty;
    assign rd_data = slot_reg[rd_ptr_reg];

    // Storage
    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            slot_reg[wr_ptr_reg] <= wr_data;
        end
    end

    // Pointers and fill level
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_wr)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (do_rd)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            unique case ({do_wr, do_rd})
                2'b10:   count_reg <= count_reg + 1'b1;
                2'b01:   count_reg <= count_reg - 1'b1;
                default: count_reg <= count_reg;
            endcase
        end
    end

endmodule

`default_nettype wire

FILE: src/tsln_back.sv
// Back end: steps through each command and emits one output byte per beat
`default_nettype none

module tsln_back (
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  tsln_pkg::cmd_t  cmd_data,
    input  wire logic       cmd_empty,
    output logic            cmd_rd,
    output logic            empty,
    input  wire logic       pop,
    output logic [7:0]      out_byte,
    output logic            run_last
);
    import tsln_pkg::*;

`include "text_stream_line_numberer_core_macros.svh"

    logic [POS_W-1:0] step_reg;
    logic [POS_W-1:0] pos;
    logic             last;
    logic             advance;
    logic [7:0]       num_char [NUMBER_DIGITS];
    logic             upper_nz [NUMBER_DIGITS];
    logic [7:0]       byte_sel;
    logic             out_valid_reg;
    logic [7:0]       out_byte_reg;
    logic             run_last_reg;

    // Position within the head command; plain commands start at the body
    assign pos  = cmd_data.has_num ? step_reg : step_reg + POS_W'(POS_BODY);
    assign last = (pos == POS_W'(POS_BODY) + POS_W'(cmd_data.two_body));

    // Line number characters with leading zeros blanked
    always_comb
    begin
        for (int i = NUMBER_DIGITS - 1; i >= 0; i--)
        begin
            if (i == NUMBER_DIGITS - 1)
            begin
                upper_nz[i] = (cmd_data.digits[4*i +: 4] != 4'd0);
            end
            else
            begin
                upper_nz[i] = upper_nz[i+1] || (cmd_data.digits[4*i +: 4] != 4'd0);
            end
            if (upper_nz[i] || i == 0)
            begin
                num_char[i] = CH_ZERO + ((cmd_data.digits[4*i +: 4] > 4'd9) ?
                              8'd9 : {4'd0, cmd_data.digits[4*i +: 4]});
            end
            else
            begin
                num_char[i] = CH_SPACE;
            end
        end
    end

    // Byte for the current position
    always_comb
    begin
        byte_sel = CH_SPACE;
        priority if (pos == POS_W'(POS_BODY))
        begin
            byte_sel = cmd_data.body0;
        end
        else if (pos > POS_W'(POS_BODY))
        begin
            byte_sel = cmd_data.body1;
        end
        else if (pos < POS_W'(NUMBER_DIGITS))
        begin
            for (int i = 0; i < NUMBER_DIGITS; i++)
            begin
                if (pos == POS_W'(NUMBER_DIGITS - 1 - i))
                begin
                    byte_sel = num_char[i];
                end
            end
        end
        else
        begin
            byte_sel = CH_SPACE;
        end
    end

    // Output register is free when empty or being popped this beat
    assign advance = !cmd_empty && (!out_valid_reg || pop);
    assign cmd_rd  = advance && last;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (advance)
            begin
                step_reg      <= last ? '0 : step_reg + 1'b1;
                out_valid_reg <= 1'b1;
            end
            else if (pop)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Output payload
    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            out_byte_reg <= byte_sel;
            run_last_reg <= last;
        end
    end

    assign empty    = !out_valid_reg;
    assign out_byte = out_byte_reg;
    assign run_last = run_last_reg;

    // Checks
    `TSLN_ASSERT_NOW(a_pos_in_range, !cmd_empty, pos <= POS_W'(POS_BODY + 1), "sequencer position past end of command")
    `TSLN_ASSERT_NEXT(a_run_continues, advance && !last, !cmd_empty && step_reg != '0, "command left queue before its last byte")
    `TSLN_ASSERT_NOW(a_idle_step_zero, cmd_empty, step_reg == '0, "sequencer mid-command with empty queue")

endmodule

`default_nettype wire

FILE: src/text_stream_line_numberer_core.sv
// An accepted byte is written to the command queue, then expanded into the registered output port.
// Throughput: one output byte per cycle from the back-end sequencer while the queue holds a command and
//   the output is free or popped. A plain byte gives 1 byte, an escaped byte 2, a line number 8 more.
// A 4-entry command queue lets the front keep accepting while the sequencer expands.
// Reset (rst_n low, asynchronous): options off, line counter at 1, command queue and output register empty.
// Dropped newlines (squeeze) are accepted without a queue entry and produce no output.
`default_nettype none

module text_stream_line_numberer_core (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           cfg_we,
    input  wire logic [tsln_pkg::CFG_IDX_W-1:0] cfg_index,
    input  wire logic                           cfg_data,
    input  wire logic                           push,
    output logic                                full,
    input  wire logic [7:0]                     in_byte,
    output logic                                empty,
    input  wire logic                           pop,
    output logic [7:0]                          out_byte,
    output logic                                run_last
);
    import tsln_pkg::*;

    logic cmd_wr;
    cmd_t cmd_wr_data;
    logic cmd_full;
    logic cmd_rd;
    cmd_t cmd_rd_data;
    logic cmd_empty;

    // Front end: classify and number
    tsln_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .push      (push),
        .in_byte   (in_byte),
        .full      (full),
        .cmd_wr    (cmd_wr),
        .cmd_data  (cmd_wr_data),
        .cmd_full  (cmd_full)
    );

    // Decoupling queue
    tsln_cmd_queue u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr      (cmd_wr),
        .wr_data (cmd_wr_data),
        .full    (cmd_full),
        .rd      (cmd_rd),
        .rd_data (cmd_rd_data),
        .empty   (cmd_empty)
    );

    // Back end: expand into output beats
    tsln_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_data  (cmd_rd_data),
        .cmd_empty (cmd_empty),
        .cmd_rd    (cmd_rd),
        .empty     (empty),
        .pop       (pop),
        .out_byte  (out_byte),
        .run_last  (run_last)
    );

endmodule

`default_nettype wire

FILE: dv/tb_text_stream_line_numberer_core.sv
// Self-checking testbench for the line numbering text filter core
`timescale 1ns / 100ps

module tb_text_stream_line_numberer_core;
    import tsln_pkg::*;

    localparam int WATCHDOG_LIMIT  = 4000;
    localparam int SETTLE_CYCLES   = 12;
    localparam int RANDOM_PHASES   = 6;
    localparam int ITEMS_PER_PHASE = 38;
    localparam int CARRY_LINES     = 20;

    // Indexes past the last register; writes there must be ignored
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_LO = 3'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_HI = 3'd7;

    typedef struct packed {
        logic show_nonprint;
        logic show_tabs;
        logic show_ends;
        logic squeeze_blank;
        logic number_nonblank;
        logic number_all;
    } opts_t;

    typedef struct {
        logic [7:0] data;
        logic       last;
    } out_beat_t;

    // Predicts the formatted byte stream and checks it beat by beat
    class line_format_scoreboard;
        bit               number_all;
        bit               number_nonblank;
        bit               squeeze_blank;
        bit               show_ends;
        bit               show_tabs;
        bit               show_nonprint;
        logic [1:0]       blank_run;
        logic [BCD_W-1:0] line_bcd;
        bit               at_line_start;
        out_beat_t        pending_out_bytes[$];
        int               errors;

        function new();
            number_all      = 1'b0;
            number_nonblank = 1'b0;
            squeeze_blank   = 1'b0;
            show_ends       = 1'b0;
            show_tabs       = 1'b0;
            show_nonprint   = 1'b0;
            blank_run       = 2'd0;
            line_bcd        = 1;
            at_line_start   = 1'b1;
            errors          = 0;
        endfunction

        function void set_option(logic [CFG_IDX_W-1:0] idx, logic v);
            case (idx)
                CFG_NUMBER_ALL:      number_all      = v;
                CFG_NUMBER_NONBLANK: number_nonblank = v;
                CFG_SQUEEZE_BLANK:   squeeze_blank   = v;
                CFG_SHOW_ENDS:       show_ends       = v;
                CFG_SHOW_TABS:       show_tabs       = v;
                CFG_SHOW_NONPRINT:   show_nonprint   = v;
                default: ;
            endcase
        endfunction

        // BCD increment that sticks at all nines
        function void advance_line_count();
            logic [BCD_W-1:0] nines;
            for (int i = 0; i < NUMBER_DIGITS; i++)
            begin
                nines[4*i +: 4] = 4'd9;
            end
            if (line_bcd == nines)
            begin
                return;
            end
            for (int i = 0; i < NUMBER_DIGITS; i++)
            begin
                if (line_bcd[4*i +: 4] >= 4'd9)
                begin
                    line_bcd[4*i +: 4] = 4'd0;
                end
                else
                begin
                    line_bcd[4*i +: 4] = line_bcd[4*i +: 4] + 4'd1;
                    break;
                end
            end
        endfunction

        // Expand one accepted input byte into its output beats
        function void note_byte_in(logic [7:0] c);
            logic [7:0] run[$];
            logic       is_nl;
            logic       lead;
            logic [3:0] d;
            out_beat_t  beat;
            is_nl = (c == CH_NL);

            // squeeze: a third newline in a row vanishes
            if (is_nl && squeeze_blank)
            begin
                if (blank_run >= 2'd2)
                begin
                    return;
                end
                blank_run = blank_run + 2'd1;
            end
            else
            begin
                blank_run = 2'd0;
            end

            // line number prefix, leading zeros shown as spaces
            if (at_line_start)
            begin
                if ((number_all && !number_nonblank) || (number_nonblank && !is_nl))
                begin
                    lead = 1'b1;
                    for (int i = NUMBER_DIGITS - 1; i >= 0; i--)
                    begin
                        d = line_bcd[4*i +: 4];
                        if (d != 4'd0 || i == 0)
                        begin
                            lead = 1'b0;
                        end
                        run.push_back(lead ? CH_SPACE : CH_ZERO + {4'd0, d});
                    end
                    run.push_back(CH_SPACE);
                    run.push_back(CH_SPACE);
                    advance_line_count();
                end
                at_line_start = 1'b0;
            end

            // body: newline, tab, control, delete or plain byte
            if (is_nl)
            begin
                if (show_ends)
                begin
                    run.push_back(CH_DOLLAR);
                end
                run.push_back(CH_NL);
                at_line_start = 1'b1;
            end
            else if (c == CH_TAB && show_tabs)
            begin
                run.push_back(CH_CARET);
                run.push_back(CH_UPPERI);
            end
            else if (c < CH_SPACE && c != CH_TAB && show_nonprint)
            begin
                run.push_back(CH_CARET);
                run.push_back(c + CTRL_OFS);
            end
            else if (c == CH_DEL && show_nonprint)
            begin
                run.push_back(CH_CARET);
                run.push_back(CH_QMARK);
            end
            else
            begin
                run.push_back(c);
            end

            foreach (run[k])
            begin
                beat.data = run[k];
                beat.last = (k == run.size() - 1);
                pending_out_bytes.push_back(beat);
            end
        endfunction

        function void check_byte_out(logic [7:0] data, logic last);
            out_beat_t want;
            if (pending_out_bytes.size() == 0)
            begin
                errors++;
                $display("%0t: unexpected beat: expected none, actual byte %h last %b",
                         $time, data, last);
                return;
            end
            want = pending_out_bytes.pop_front();
            if (data !== want.data)
            begin
                errors++;
                $display("%0t: out_byte mismatch: expected %h, actual %h",
                         $time, want.data, data);
            end
            if (last !== want.last)
            begin
                errors++;
                $display("%0t: run_last mismatch: expected %b, actual %b",
                         $time, want.last, last);
            end
        endfunction

        function void report_leftover();
            if (pending_out_bytes.size() != 0)
            begin
                errors++;
                $display("%0t: %0d expected beats never arrived, expected byte %h, actual none",
                         $time, pending_out_bytes.size(), pending_out_bytes[0].data);
            end
        endfunction
    endclass

    logic                 clk       = 1'b0;
    logic                 rst_n     = 1'b0;
    logic                 cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = CFG_NUMBER_ALL;
    logic                 cfg_data  = 1'b0;
    logic                 push      = 1'b0;
    logic                 full;
    logic [7:0]           in_byte   = 8'h00;
    logic                 empty;
    logic                 pop       = 1'b0;
    logic [7:0]           out_byte;
    logic                 run_last;

    int idle_pct    = 0;
    int stall_pct   = 0;
    int idle_cycles = 0;

    line_format_scoreboard sb = new();

    text_stream_line_numberer_core DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .push      (push),
        .full      (full),
        .in_byte   (in_byte),
        .empty     (empty),
        .pop       (pop),
        .out_byte  (out_byte),
        .run_last  (run_last)
    );

    always #1 clk = ~clk;

    // Monitor: config writes, accepted input beats, accepted output beats; random pop
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            pop <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                sb.set_option(cfg_index, cfg_data);
            end
            if (push && !full)
            begin
                sb.note_byte_in(in_byte);
            end
            if (pop && !empty)
            begin
                sb.check_byte_out(out_byte, run_last);
            end
            pop <= ($urandom_range(99) >= stall_pct);
        end
    end

    // Watchdog: cycles without any beat or register write
    always @(posedge clk)
    begin
        if (!rst_n || cfg_we || (push && !full) || (pop && !empty))
        begin
            idle_cycles <= 0;
        end
        else
        begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial
    begin
        wait (idle_cycles >= WATCHDOG_LIMIT);
        $display("status: fail");
        $finish;
    end

    // One input beat, with random sender gaps ahead of it
    task automatic send_byte(logic [7:0] b);
        while ($urandom_range(99) < idle_pct)
        begin
            push <= 1'b0;
            @(posedge clk);
        end
        push    <= 1'b1;
        in_byte <= b;
        @(posedge clk);
        while (full)
        begin
            @(posedge clk);
        end
    endtask

    // Wait until all predicted output has drained and dropped bytes have left the pipe
    task automatic settle();
        push <= 1'b0;
        @(posedge clk);
        while (sb.pending_out_bytes.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Leaves cfg_we high; the caller lowers it after the last write
    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic v);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= v;
        @(posedge clk);
    endtask

    task automatic apply_opts(opts_t o);
        write_reg(CFG_NUMBER_ALL,      o.number_all);
        write_reg(CFG_NUMBER_NONBLANK, o.number_nonblank);
        write_reg(CFG_SQUEEZE_BLANK,   o.squeeze_blank);
        write_reg(CFG_SHOW_ENDS,       o.show_ends);
        write_reg(CFG_SHOW_TABS,       o.show_tabs);
        write_reg(CFG_SHOW_NONPRINT,   o.show_nonprint);
        write_reg($urandom_range(1) ? CFG_SPARE_HI : CFG_SPARE_LO, 1'($urandom));
        cfg_we <= 1'b0;
    endtask

    // Text-like byte mix with a tail of arbitrary bytes
    function automatic logic [7:0] random_text_byte();
        int r;
        r = $urandom_range(99);
        if (r < 45)
        begin
            return 8'($urandom_range(8'h7E, 8'h20));
        end
        else if (r < 62)
        begin
            return CH_NL;
        end
        else if (r < 70)
        begin
            return CH_TAB;
        end
        else if (r < 79)
        begin
            return 8'($urandom_range(8'h1F, 8'h00));
        end
        else if (r < 83)
        begin
            return CH_DEL;
        end
        return 8'($urandom_range(255));
    endfunction

    initial
    begin
        opts_t opts;
        int    sent;
        int    burst;

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Numbered lines with squeeze and every escape shown
        opts = '{show_nonprint: 1'b1, show_tabs: 1'b1, show_ends: 1'b1,
                 squeeze_blank: 1'b1, number_nonblank: 1'b0, number_all: 1'b1};
        apply_opts(opts);
        send_byte(8'h41);
        send_byte(8'h00);
        send_byte(CH_TAB);
        send_byte(CH_NL);
        send_byte(CH_NL);
        send_byte(CH_NL);
        send_byte(CH_NL);   // dropped by squeeze
        send_byte(8'h1F);
        send_byte(CH_DEL);
        send_byte(8'h80);
        send_byte(8'hFF);
        send_byte(8'h7E);
        send_byte(CH_NL);
        settle();

        // Everything on: nonblank numbering overrides number-all
        apply_opts('1);
        send_byte(CH_NL);
        send_byte(CH_NL);
        send_byte(8'h61);
        send_byte(CH_TAB);
        send_byte(CH_NL);
        send_byte(CH_NL);
        send_byte(CH_NL);   // third newline in a row, dropped
        settle();

        // Nonprint alone: tab passes through untouched
        opts = '{show_nonprint: 1'b1, show_tabs: 1'b0, show_ends: 1'b0,
                 squeeze_blank: 1'b0, number_nonblank: 1'b0, number_all: 1'b0};
        apply_opts(opts);
        send_byte(CH_TAB);
        send_byte(8'h01);
        send_byte(8'h1B);
        send_byte(CH_NL);
        settle();

        // Random text under varying options and flow control
        for (int p = 0; p < RANDOM_PHASES; p++)
        begin
            if (p == 0)
            begin
                opts = '0;
            end
            else if (p == 1)
            begin
                opts = '1;
            end
            else
            begin
                opts = opts_t'($urandom);
            end
            if (p >= 4)
            begin
                opts.number_all = 1'b1;
            end
            apply_opts(opts);

            case (p % 4)
                0:       begin idle_pct = 0;  stall_pct = 0;  end
                1:       begin idle_pct = 56; stall_pct = 0;  end
                2:       begin idle_pct = 0;  stall_pct = 56; end
                default: begin idle_pct = 10; stall_pct = 10; end
            endcase

            sent = 0;
            while (sent < ITEMS_PER_PHASE)
            begin
                if ($urandom_range(9) == 0)
                begin
                    burst = $urandom_range(5, 2);
                    repeat (burst) send_byte(CH_NL);
                    sent += burst;
                end
                else
                begin
                    send_byte(random_text_byte());
                    sent++;
                end
            end
            settle();

            // A run of numbered empty lines carries through the tens digit
            if (p == 3)
            begin
                opts = opts_t'($urandom);
                opts.number_all      = 1'b1;
                opts.number_nonblank = 1'b0;
                opts.squeeze_blank   = 1'b0;
                apply_opts(opts);
                idle_pct  = 0;
                stall_pct = 0;
                repeat (CARRY_LINES) send_byte(CH_NL);
                settle();
            end
        end

        sb.report_leftover();
        if (sb.errors == 0)
        begin
            $display("status: pass");
        end
        else
        begin
            $display("status: fail");
        end
        $finish;
    end

endmodule

FILE: text_stream_line_numberer_core.f
+incdir+src
src/tsln_pkg.sv
src/tsln_front.sv
src/tsln_cmd_queue.sv
src/tsln_back.sv
src/text_stream_line_numberer_core.sv
dv/tb_text_stream_line_numberer_core.sv
